FILE: rtl/core/fpsp_pkg.sv
// fpsp_pkg: shared types and codes for the field stream parser
// result kinds, parse phases and the record passed from front to back
// no dependencies
`timescale 1ns / 1ps

package fpsp_pkg;

	localparam logic [2:0] KIND_VARINT  = 3'd0;
	localparam logic [2:0] KIND_PAYLOAD = 3'd1;
	localparam logic [2:0] KIND_EMPTY   = 3'd2;
	localparam logic [2:0] KIND_BAD     = 3'd3;
	localparam logic [2:0] KIND_DONE    = 3'd4;

	localparam logic [1:0] PH_TAG     = 2'd0;
	localparam logic [1:0] PH_VALUE   = 2'd1;
	localparam logic [1:0] PH_LENGTH  = 2'd2;
	localparam logic [1:0] PH_PAYLOAD = 2'd3;

	localparam logic [2:0] WT_VARINT = 3'd0;
	localparam logic [2:0] WT_LENGTH = 3'd2;

	localparam logic [3:0] MAX_GROUPS = 4'd10;

	localparam int QUEUE_DEPTH = 4;
	localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic        has_main;
		logic [2:0]  kind;
		logic [3:0]  field_id;
		logic [63:0] varint_value;
		logic [7:0]  payload_byte;
		logic        payload_last;
		logic        has_done;
		logic [31:0] bytes_parsed;
		logic        truncated;
	} rec_t;

endpackage

FILE: rtl/core/fpsp_front.sv
// fpsp_front: takes one byte per transfer, runs the tag/varint/payload parse
// and emits one record per byte that causes any result
// depends on fpsp_pkg
`timescale 1ns / 1ps

module fpsp_front import fpsp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] data_byte,
	input  logic       end_of_buffer,
	output logic       rec_push,
	output rec_t       rec
);

	logic [1:0]  phase_q, phase_n;
	logic [3:0]  field_q, field_n;
	logic [63:0] acc_q, acc_n, acc_add;
	logic [3:0]  cnt_q, cnt_n, cnt_add;
	logic [31:0] rem_q, rem_n;
	logic [31:0] consumed_q, consumed_n;
	logic [31:0] committed_q, committed_n;
	logic [31:0] len_clip;
	logic        commit;
	logic        has_main;
	logic [2:0]  kind_n;
	logic [63:0] value_n;
	logic [7:0]  pbyte_n;
	logic        plast_n;

	// one 7-bit group into the accumulator at the current group slot
	always_comb begin
		acc_add = acc_q;
		for (int g = 0; g < 9; g++) begin
			if (cnt_q == 4'(g)) begin
				acc_add[7*g +: 7] = acc_q[7*g +: 7] | data_byte[6:0];
			end
		end
		if (cnt_q == 4'd9) begin
			acc_add[63] = acc_q[63] | data_byte[0];
		end
		cnt_add = (cnt_q < MAX_GROUPS) ? cnt_q + 4'd1 : cnt_q;
	end

	assign len_clip = (|acc_add[63:32]) ? 32'hFFFF_FFFF : acc_add[31:0];
	assign consumed_n = consumed_q + 32'd1;

	always_comb begin
		phase_n  = phase_q;
		field_n  = field_q;
		acc_n    = acc_q;
		cnt_n    = cnt_q;
		rem_n    = rem_q;
		commit   = 1'b0;
		has_main = 1'b0;
		kind_n   = KIND_VARINT;
		value_n  = '0;
		pbyte_n  = '0;
		plast_n  = 1'b0;
		case (phase_q)
			PH_TAG: begin
				field_n = data_byte[6:3];
				acc_n   = '0;
				cnt_n   = '0;
				if (data_byte[2:0] == WT_VARINT) begin
					phase_n = PH_VALUE;
				end else if (data_byte[2:0] == WT_LENGTH) begin
					phase_n = PH_LENGTH;
				end else begin
					has_main = 1'b1;
					kind_n   = KIND_BAD;
				end
			end
			PH_VALUE: begin
				acc_n = acc_add;
				cnt_n = cnt_add;
				if (!data_byte[7]) begin
					has_main = 1'b1;
					kind_n   = KIND_VARINT;
					value_n  = acc_add;
					commit   = 1'b1;
					phase_n  = PH_TAG;
				end
			end
			PH_LENGTH: begin
				acc_n = acc_add;
				cnt_n = cnt_add;
				if (!data_byte[7]) begin
					rem_n = len_clip;
					if (len_clip == '0) begin
						has_main = 1'b1;
						kind_n   = KIND_EMPTY;
						commit   = 1'b1;
						phase_n  = PH_TAG;
					end else begin
						phase_n = PH_PAYLOAD;
					end
				end
			end
			PH_PAYLOAD: begin
				rem_n    = rem_q - 32'd1;
				has_main = 1'b1;
				kind_n   = KIND_PAYLOAD;
				pbyte_n  = data_byte;
				plast_n  = (rem_q == 32'd1);
				if (rem_q == 32'd1) begin
					commit  = 1'b1;
					phase_n = PH_TAG;
				end
			end
			default: begin
				phase_n = PH_TAG;
			end
		endcase
		committed_n = commit ? consumed_n : committed_q;
	end

	always_comb begin
		rec.has_main     = has_main;
		rec.kind         = kind_n;
		rec.field_id     = field_n;
		rec.varint_value = value_n;
		rec.payload_byte = pbyte_n;
		rec.payload_last = plast_n;
		rec.has_done     = end_of_buffer;
		rec.bytes_parsed = committed_n;
		rec.truncated    = (phase_n != PH_TAG);
	end

	assign rec_push = accept && (has_main || end_of_buffer);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_TAG;
			field_q     <= '0;
			acc_q       <= '0;
			cnt_q       <= '0;
			rem_q       <= '0;
			consumed_q  <= '0;
			committed_q <= '0;
		end else if (accept) begin
			if (end_of_buffer) begin
				phase_q     <= PH_TAG;
				field_q     <= '0;
				acc_q       <= '0;
				cnt_q       <= '0;
				rem_q       <= '0;
				consumed_q  <= '0;
				committed_q <= '0;
			end else begin
				phase_q     <= phase_n;
				field_q     <= field_n;
				acc_q       <= acc_n;
				cnt_q       <= cnt_n;
				rem_q       <= rem_n;
				consumed_q  <= consumed_n;
				committed_q <= committed_n;
			end
		end
	end

endmodule

FILE: rtl/core/fpsp_queue.sv
// fpsp_queue: short record queue between parse front and result back
// depends on fpsp_pkg
`timescale 1ns / 1ps

module fpsp_queue import fpsp_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  rec_t wdata,
	output logic full,
	input  logic pop,
	output logic nonempty,
	output rec_t rdata
);

	rec_t                 mem_q [QUEUE_DEPTH];
	logic [QUEUE_AW-1:0]  wptr_q, rptr_q;
	logic [QUEUE_AW:0]    count_q;
	logic                 do_push, do_pop;

	assign full     = (count_q == (QUEUE_AW+1)'(QUEUE_DEPTH));
	assign nonempty = (count_q != '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && nonempty;
	assign rdata    = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= wptr_q + QUEUE_AW'(1);
			end
			if (do_pop) begin
				rptr_q <= rptr_q + QUEUE_AW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + (QUEUE_AW+1)'(1);
				2'b01:   count_q <= count_q - (QUEUE_AW+1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

FILE: rtl/core/fpsp_back.sv
// fpsp_back: output register that expands each record into its one or two
// results (field result, then done report) and serves the pop side
// depends on fpsp_pkg
`timescale 1ns / 1ps

module fpsp_back import fpsp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rec_valid,
	input  rec_t        rec,
	output logic        rec_pop,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  kind,
	output logic [3:0]  field_id,
	output logic [63:0] varint_value,
	output logic [7:0]  payload_byte,
	output logic        payload_last,
	output logic [31:0] bytes_parsed,
	output logic        truncated,
	output logic        run_last
);

	rec_t cur_q;
	logic valid_q;
	logic second_q;
	logic last_of_rec;
	logic advance;

	assign last_of_rec = second_q || !cur_q.has_done;
	assign advance     = !valid_q || (pop && last_of_rec);
	assign rec_pop     = rec_valid && advance;
	assign empty       = !valid_q;

	always_ff @(posedge clk) begin
		if (rec_pop) begin
			cur_q <= rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= 1'b0;
			second_q <= 1'b0;
		end else if (advance) begin
			valid_q  <= rec_valid;
			second_q <= !rec.has_main;
		end else if (pop) begin
			second_q <= 1'b1;
		end
	end

	always_comb begin
		if (second_q) begin
			kind         = KIND_DONE;
			field_id     = '0;
			varint_value = '0;
			payload_byte = '0;
			payload_last = 1'b0;
			bytes_parsed = cur_q.bytes_parsed;
			truncated    = cur_q.truncated;
			run_last     = 1'b1;
		end else begin
			kind         = cur_q.kind;
			field_id     = cur_q.field_id;
			varint_value = cur_q.varint_value;
			payload_byte = cur_q.payload_byte;
			payload_last = cur_q.payload_last;
			bytes_parsed = '0;
			truncated    = 1'b0;
			run_last     = !cur_q.has_done;
		end
	end

endmodule

FILE: rtl/core/protobuf_field_stream_parser.sv
// protobuf_field_stream_parser: top level of the byte-wise field stream parser
// depends on fpsp_pkg, fpsp_front, fpsp_queue, fpsp_back
//
//   channel  | handshake        | transfer when      | payload
//   ---------+------------------+--------------------+---------------------------------
//   input    | push / full      | push & !full       | data_byte, end_of_buffer
//   result   | empty / pop      | pop & !empty       | kind, field_id, varint_value,
//            |                  |                    | payload_byte, payload_last,
//            |                  |                    | bytes_parsed, truncated, run_last
//
// one byte per cycle is parsed in the front while full is low; a byte's first result
// is written to the record queue at the transfer edge and then loaded into the
// output register once that register is free
// a byte with a field result and end of buffer yields two results, which the
// output register presents over two pops; the 4-entry record queue absorbs this
// full rises only when the record queue holds 4 records; empty and full are
// registered, with no path from pop to full
// reset clears parse state, queue pointers and output valid; no clearing pass
`timescale 1ns / 1ps

module protobuf_field_stream_parser import fpsp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  data_byte,
	input  logic        end_of_buffer,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  kind,
	output logic [3:0]  field_id,
	output logic [63:0] varint_value,
	output logic [7:0]  payload_byte,
	output logic        payload_last,
	output logic [31:0] bytes_parsed,
	output logic        truncated,
	output logic        run_last
);

	rec_t front_rec, head_rec;
	logic front_push;
	logic q_full, q_nonempty, q_pop;
	logic accept;

	assign full   = q_full;
	assign accept = push && !q_full;

	fpsp_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.data_byte     (data_byte),
		.end_of_buffer (end_of_buffer),
		.rec_push      (front_push),
		.rec           (front_rec)
	);

	fpsp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (front_push),
		.wdata    (front_rec),
		.full     (q_full),
		.pop      (q_pop),
		.nonempty (q_nonempty),
		.rdata    (head_rec)
	);

	fpsp_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.rec_valid    (q_nonempty),
		.rec          (head_rec),
		.rec_pop      (q_pop),
		.empty        (empty),
		.pop          (pop),
		.kind         (kind),
		.field_id     (field_id),
		.varint_value (varint_value),
		.payload_byte (payload_byte),
		.payload_last (payload_last),
		.bytes_parsed (bytes_parsed),
		.truncated    (truncated),
		.run_last     (run_last)
	);

	a_done_closes_run: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && kind == KIND_DONE) |-> (run_last && field_id == 4'd0
			&& varint_value == 64'd0))
		else $error("done report must close the run with zero field data");

	a_last_only_on_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && payload_last) |-> (kind == KIND_PAYLOAD))
		else $error("payload_last on a non-payload result");

	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !front_push)
		else $error("record pushed into a full queue");

	a_pop_needs_record: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> q_nonempty)
		else $error("record popped from an empty queue");

	a_second_follows_first: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop && !run_last) |=> (!empty && kind == KIND_DONE))
		else $error("done report missing after a field result");

endmodule

FILE: tb/sv/field_result_checker.sv
// field_result_checker: decodes the accepted byte stream on its own and checks
// every result transfer of the field stream parser against the oldest prediction
// depends on fpsp_pkg
`timescale 1ns / 1ps

module field_result_checker import fpsp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  logic        full,
	input  logic [7:0]  data_byte,
	input  logic        end_of_buffer,
	input  logic        empty,
	input  logic        pop,
	input  logic [2:0]  kind,
	input  logic [3:0]  field_id,
	input  logic [63:0] varint_value,
	input  logic [7:0]  payload_byte,
	input  logic        payload_last,
	input  logic [31:0] bytes_parsed,
	input  logic        truncated,
	input  logic        run_last,
	output int          failures,
	output int          waiting
);

	typedef struct packed {
		logic [2:0]  kind;
		logic [3:0]  field_id;
		logic [63:0] varint_value;
		logic [7:0]  payload_byte;
		logic        payload_last;
		logic [31:0] bytes_parsed;
		logic        truncated;
		logic        run_last;
	} field_result_t;

	field_result_t expected_results[$];

	logic [1:0]  phase;
	logic [3:0]  cur_id;
	logic [63:0] acc;
	logic [3:0]  groups;
	logic [31:0] remaining;
	logic [31:0] consumed;
	logic [31:0] committed;

	function automatic void clear_parse();
		phase = PH_TAG;
		cur_id = '0;
		acc = '0;
		groups = '0;
		remaining = '0;
		consumed = '0;
		committed = '0;
	endfunction

	function automatic void add_group(input logic [7:0] b);
		if (groups < MAX_GROUPS) begin
			acc = acc | (64'(b[6:0]) << (7 * int'(groups)));
			groups = groups + 4'd1;
		end
	endfunction

	function automatic void decode_byte(input logic [7:0] b, input logic eob);
		field_result_t r[2];
		int n;
		n = 0;
		r[0] = '0;
		r[1] = '0;
		consumed = consumed + 32'd1;
		case (phase)
			PH_TAG: begin
				cur_id = b[6:3];
				acc = '0;
				groups = '0;
				if (b[2:0] == WT_VARINT) begin
					phase = PH_VALUE;
				end else if (b[2:0] == WT_LENGTH) begin
					phase = PH_LENGTH;
				end else begin
					r[n].kind = KIND_BAD;
					r[n].field_id = cur_id;
					n++;
				end
			end
			PH_VALUE: begin
				add_group(b);
				if (!b[7]) begin
					r[n].kind = KIND_VARINT;
					r[n].field_id = cur_id;
					r[n].varint_value = acc;
					n++;
					committed = consumed;
					phase = PH_TAG;
				end
			end
			PH_LENGTH: begin
				add_group(b);
				if (!b[7]) begin
					// lengths beyond 32 bits saturate
					remaining = (acc[63:32] != '0) ? '1 : acc[31:0];
					if (remaining == '0) begin
						r[n].kind = KIND_EMPTY;
						r[n].field_id = cur_id;
						n++;
						committed = consumed;
						phase = PH_TAG;
					end else begin
						phase = PH_PAYLOAD;
					end
				end
			end
			default: begin
				remaining = remaining - 32'd1;
				r[n].kind = KIND_PAYLOAD;
				r[n].field_id = cur_id;
				r[n].payload_byte = b;
				r[n].payload_last = (remaining == '0);
				n++;
				if (remaining == '0) begin
					committed = consumed;
					phase = PH_TAG;
				end
			end
		endcase
		if (eob) begin
			r[n].kind = KIND_DONE;
			r[n].bytes_parsed = committed;
			r[n].truncated = (phase != PH_TAG);
			n++;
			clear_parse();
		end
		if (n > 0)
			r[n - 1].run_last = 1'b1;
		for (int i = 0; i < n; i++)
			expected_results.push_back(r[i]);
	endfunction

	function automatic void note_failure(input string msg);
		failures++;
		if (failures <= 10)
			$display("%0t: %s", $realtime, msg);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		field_result_t got;
		field_result_t want;
		if (!arst_n) begin
			clear_parse();
			expected_results.delete();
			failures = 0;
			waiting = 0;
		end else begin
			if (push && !full)
				decode_byte(data_byte, end_of_buffer);
			if (pop && !empty) begin
				got = '{kind, field_id, varint_value, payload_byte, payload_last,
					bytes_parsed, truncated, run_last};
				if (expected_results.size() == 0) begin
					note_failure($sformatf("unexpected result: kind %0d id %0d value %h",
						kind, field_id, varint_value));
				end else begin
					want = expected_results.pop_front();
					if (got !== want)
						note_failure($sformatf({"mismatch: expected kind %0d id %0d value %h ",
							"byte %h last %b parsed %0d trunc %b run_last %b; got kind %0d ",
							"id %0d value %h byte %h last %b parsed %0d trunc %b run_last %b"},
							want.kind, want.field_id, want.varint_value, want.payload_byte,
							want.payload_last, want.bytes_parsed, want.truncated,
							want.run_last, got.kind, got.field_id, got.varint_value,
							got.payload_byte, got.payload_last, got.bytes_parsed,
							got.truncated, got.run_last));
				end
			end
			waiting = expected_results.size();
		end
	end

endmodule

FILE: tb/sv/testbench.sv
// testbench: drives encoded field streams into the field stream parser and pops
// its results under varying idle rates; field_result_checker does the checking
// depends on fpsp_pkg, protobuf_field_stream_parser, field_result_checker
`timescale 1ns / 1ps

module testbench;
	import fpsp_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	logic [7:0]  data_byte;
	logic        end_of_buffer;
	logic        empty;
	logic        pop;
	logic [2:0]  kind;
	logic [3:0]  field_id;
	logic [63:0] varint_value;
	logic [7:0]  payload_byte;
	logic        payload_last;
	logic [31:0] bytes_parsed;
	logic        truncated;
	logic        run_last;
	int          failures;
	int          waiting;

	int send_idle;
	int recv_idle;
	int bytes_sent;

	// bit 8 marks end of buffer
	logic [8:0] opening [27] = '{
		9'h000, 9'h100,
		9'h07F,
		9'h012, 9'h000,
		9'h01A, 9'h001, 9'h055,
		9'h078, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF,
		9'h0FF, 9'h0FF, 9'h07F,
		9'h022, 9'h080, 9'h080, 9'h080, 9'h080, 9'h010, 9'h1AA
	};

	protobuf_field_stream_parser dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.data_byte(data_byte),
		.end_of_buffer(end_of_buffer),
		.empty(empty),
		.pop(pop),
		.kind(kind),
		.field_id(field_id),
		.varint_value(varint_value),
		.payload_byte(payload_byte),
		.payload_last(payload_last),
		.bytes_parsed(bytes_parsed),
		.truncated(truncated),
		.run_last(run_last)
	);

	field_result_checker checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.data_byte(data_byte),
		.end_of_buffer(end_of_buffer),
		.empty(empty),
		.pop(pop),
		.kind(kind),
		.field_id(field_id),
		.varint_value(varint_value),
		.payload_byte(payload_byte),
		.payload_last(payload_last),
		.bytes_parsed(bytes_parsed),
		.truncated(truncated),
		.run_last(run_last),
		.failures(failures),
		.waiting(waiting)
	);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	always @(negedge clk) begin
		pop <= arst_n && ($urandom_range(99) >= recv_idle);
	end

	task automatic send_byte(input logic [7:0] b, input logic eob);
		logic accepted;
		accepted = 1'b0;
		while (!accepted) begin
			if ($urandom_range(99) < send_idle) begin
				push <= 1'b0;
			end else begin
				push <= 1'b1;
				data_byte <= b;
				end_of_buffer <= eob;
			end
			@(posedge clk);
			accepted = push && !full;
			@(negedge clk);
		end
		bytes_sent++;
	endtask

	task automatic send_field();
		logic [7:0]  field_bytes[$];
		logic [31:0] len;
		logic [2:0]  wt;
		logic [3:0]  id;
		int          pick;
		int          count;
		int          cut;
		logic        huge;
		pick = $urandom_range(99);
		id = 4'($urandom_range(15));
		huge = 1'b0;
		if (pick < 35) begin
			field_bytes.push_back({1'($urandom_range(1)), id, WT_VARINT});
			cut = $urandom_range(19);
			count = (cut == 0) ? $urandom_range(11, 13) :
				(cut == 1) ? $urandom_range(9, 10) : $urandom_range(1, 4);
			for (int i = 0; i < count; i++)
				field_bytes.push_back({i < count - 1, 7'($urandom)});
		end else if (pick < 70) begin
			field_bytes.push_back({1'($urandom_range(1)), id, WT_LENGTH});
			if ($urandom_range(19) == 0) begin
				// length above 32 bits, always cut short by end of buffer
				huge = 1'b1;
				for (int i = 0; i < 4; i++)
					field_bytes.push_back({1'b1, 7'($urandom)});
				field_bytes.push_back({1'b0, 7'($urandom_range(16, 127))});
				count = $urandom_range(3);
			end else begin
				cut = $urandom_range(49);
				len = (cut < 6) ? 32'd0 : (cut == 6) ? 32'($urandom_range(128, 140)) :
					32'($urandom_range(1, 6));
				count = int'(len);
				do begin
					field_bytes.push_back({len > 32'd127, len[6:0]});
					len = len >> 7;
				end while (len != 0);
			end
			for (int i = 0; i < count; i++)
				field_bytes.push_back(8'($urandom));
		end else if (pick < 82) begin
			cut = $urandom_range(1, 6);
			wt = (cut == 2) ? 3'd7 : 3'(cut);
			field_bytes.push_back({1'($urandom_range(1)), id, wt});
		end else begin
			count = $urandom_range(1, 3);
			for (int i = 0; i < count; i++)
				field_bytes.push_back(8'($urandom));
		end

		pick = $urandom_range(99);
		cut = -1;
		if (huge || pick < 12) begin
			cut = field_bytes.size() - 1;
		end else if (pick < 18) begin
			cut = $urandom_range(field_bytes.size() - 1);
		end
		for (int i = 0; i < field_bytes.size(); i++) begin
			send_byte(field_bytes[i], i == cut);
			if (i == cut)
				break;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		pop = 1'b0;
		data_byte = '0;
		end_of_buffer = 1'b0;
		bytes_sent = 0;
		send_idle = 17;
		recv_idle = 45;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (opening[i])
			send_byte(opening[i][7:0], opening[i][8]);

		for (int p = 0; p < 3; p++) begin
			send_idle = (p == 0) ? 17 : (p == 1) ? 45 : 0;
			recv_idle = (p == 0) ? 45 : (p == 1) ? 17 : 0;
			while (bytes_sent < 27 + 150 * (p + 1))
				send_field();
		end
		push <= 1'b0;

		while (waiting != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);

		if (failures == 0 && waiting == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

	initial begin
		#400000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/fpsp_pkg.sv
rtl/core/fpsp_front.sv
rtl/core/fpsp_queue.sv
rtl/core/fpsp_back.sv
rtl/core/protobuf_field_stream_parser.sv
tb/sv/field_result_checker.sv
tb/sv/testbench.sv
